// ----- design/sisc_pkg.sv -----
package sisc_pkg;

    localparam int ID_BITS        = 10;
    localparam int WIDE_ID_BITS   = 17;
    localparam int OUT_COUNT_BITS = 32;
    localparam int LEN_BITS       = 16;

    localparam logic OP_TOKEN = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] KIND_ITEM    = 2'd0;
    localparam logic [1:0] KIND_SET_END = 2'd1;
    localparam logic [1:0] KIND_SEQ_END = 2'd2;

    localparam logic [OUT_COUNT_BITS-1:0] MIN_SUPPORT_RESET = 32'd1;

    typedef struct packed {
        logic               opcode;
        logic [1:0]         token_kind;
        logic [ID_BITS-1:0] item_id;
    } cmd_t;

    typedef struct packed {
        logic [ID_BITS-1:0]        entry_id;
        logic [OUT_COUNT_BITS-1:0] support_count;
        logic [OUT_COUNT_BITS-1:0] nonfinal_count;
        logic                      is_frequent;
        logic [OUT_COUNT_BITS-1:0] sequence_total;
        logic [LEN_BITS-1:0]       longest_pattern;
        logic [LEN_BITS-1:0]       longest_sequence;
    } result_t;

    typedef enum logic [1:0] {
        EV_ITEM,
        EV_SET_END,
        EV_SEQ_END,
        EV_QUERY
    } event_kind_t;

    // One unit of work for the update stage.
    typedef struct packed {
        logic               valid;
        event_kind_t        kind;
        logic [ID_BITS-1:0] id;
        logic               drop;
        logic               nonfinal_ok;
    } event_t;

    // Length add that sticks at the top of the 16-bit range.
    function automatic logic [LEN_BITS-1:0] sat_add16(input logic [LEN_BITS-1:0] v,
                                                      input logic [1:0] d);
        logic [LEN_BITS:0] s;
        s = {1'b0, v} + (LEN_BITS + 1)'(d);
        return s[LEN_BITS] ? {LEN_BITS{1'b1}} : s[LEN_BITS-1:0];
    endfunction

endpackage

// ----- design/sisc_window.sv -----
module sisc_window
    import sisc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   accept,
    input  cmd_t   cmd,
    output logic   pending,
    output event_t ev
);

    typedef struct packed {
        logic               is_item;
        logic [ID_BITS-1:0] id;
    } win_tok_t;

    win_tok_t   w0_reg, w0_next;
    win_tok_t   w1_reg, w1_next;
    logic [1:0] fill_reg, fill_next;
    logic       end_pending_reg, end_pending_next;
    event_t     ev_reg, ev_next;
    win_tok_t   in_tok;
    logic       w0_dup;

    function automatic event_t tok_event(input win_tok_t t, input logic drop,
                                         input logic nf_ok);
        event_t e;
        e.valid       = 1'b1;
        e.kind        = t.is_item ? EV_ITEM : EV_SET_END;
        e.id          = t.id;
        e.drop        = drop;
        e.nonfinal_ok = nf_ok;
        return e;
    endfunction

    assign in_tok.is_item = (cmd.token_kind == KIND_ITEM);
    assign in_tok.id      = cmd.item_id;

    // The oldest token is dropped when its direct successor repeats the same item.
    assign w0_dup = w0_reg.is_item && w1_reg.is_item && (w0_reg.id == w1_reg.id);

    always_comb
    begin
        w0_next          = w0_reg;
        w1_next          = w1_reg;
        fill_next        = fill_reg;
        end_pending_next = end_pending_reg;
        ev_next          = '0;
        if (end_pending_reg)
        begin
            // Drain what is left before the end-of-sequence mark itself.
            if (fill_reg != 2'd0)
            begin
                ev_next   = tok_event(w0_reg, 1'b0, 1'b0);
                fill_next = 2'd0;
            end
            else
            begin
                ev_next.valid    = 1'b1;
                ev_next.kind     = EV_SEQ_END;
                end_pending_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (cmd.opcode == OP_QUERY)
            begin
                ev_next.valid = 1'b1;
                ev_next.kind  = EV_QUERY;
                ev_next.id    = cmd.item_id;
            end
            else
            begin
                unique case (cmd.token_kind) inside
                    KIND_SEQ_END:
                    begin
                        if (fill_reg == 2'd2)
                        begin
                            ev_next          = tok_event(w0_reg, w0_dup, 1'b0);
                            w0_next          = w1_reg;
                            fill_next        = 2'd1;
                            end_pending_next = 1'b1;
                        end
                        else if (fill_reg == 2'd1)
                        begin
                            ev_next          = tok_event(w0_reg, 1'b0, 1'b0);
                            fill_next        = 2'd0;
                            end_pending_next = 1'b1;
                        end
                        else
                        begin
                            ev_next.valid = 1'b1;
                            ev_next.kind  = EV_SEQ_END;
                        end
                    end
                    KIND_ITEM, KIND_SET_END:
                    begin
                        if (fill_reg == 2'd2)
                        begin
                            ev_next = tok_event(w0_reg, w0_dup, 1'b1);
                            w0_next = w1_reg;
                            w1_next = in_tok;
                        end
                        else if (fill_reg == 2'd1)
                        begin
                            w1_next   = in_tok;
                            fill_next = 2'd2;
                        end
                        else
                        begin
                            w0_next   = in_tok;
                            fill_next = 2'd1;
                        end
                    end
                    default:
                    begin
                        ev_next = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w0_reg          <= '0;
            w1_reg          <= '0;
            fill_reg        <= 2'd0;
            end_pending_reg <= 1'b0;
            ev_reg          <= '0;
        end
        else
        begin
            w0_reg          <= w0_next;
            w1_reg          <= w1_next;
            fill_reg        <= fill_next;
            end_pending_reg <= end_pending_next;
            ev_reg          <= ev_next;
        end
    end

    assign pending = end_pending_reg;
    assign ev      = ev_reg;

    a_no_accept_while_draining: assert property (@(posedge clk) disable iff (!rst_n)
        end_pending_reg |-> !accept)
        else $error("request accepted while the window drains");

    a_drain_ends_with_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (end_pending_reg && fill_reg == 2'd0) |=>
            (!end_pending_reg && ev_reg.valid && ev_reg.kind == EV_SEQ_END))
        else $error("window drain did not finish with the end-of-sequence event");

    a_query_passes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.opcode == OP_QUERY) |=>
            (ev_reg.valid && ev_reg.kind == EV_QUERY && ev_reg.id == $past(cmd.item_id)))
        else $error("query request was not forwarded in order");

endmodule

// ----- design/sisc_update.sv -----
module sisc_update
    import sisc_pkg::*;
#(
    parameter int ITEM_COUNT = 1024,
    parameter int COUNT_BITS = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  event_t                    ev,
    input  logic [OUT_COUNT_BITS-1:0] min_support,
    output logic                      clearing,
    output logic                      result_valid,
    output result_t                   result
);

    localparam int IDX_BITS = $clog2(ITEM_COUNT);
    localparam logic [IDX_BITS-1:0]     LAST_IDX   = IDX_BITS'(ITEM_COUNT - 1);
    localparam logic [WIDE_ID_BITS-1:0] WIDE_COUNT = WIDE_ID_BITS'(ITEM_COUNT);
    localparam logic [COUNT_BITS-1:0]   CMAX       = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic [COUNT_BITS-1:0] tag;
        logic [COUNT_BITS-1:0] sup;
        logic [COUNT_BITS-1:0] nf;
    } row_t;

    row_t tbl_mem [ITEM_COUNT];
    row_t rd_row_reg;
    row_t fwd_row_reg;
    logic [IDX_BITS-1:0] fwd_addr_reg;
    logic                fwd_valid_reg;

    logic                clear_active_reg, clear_active_next;
    logic [IDX_BITS-1:0] clear_addr_reg, clear_addr_next;

    event_t ev2_reg;

    logic [COUNT_BITS-1:0] seq_num_reg, seq_num_next;
    logic [LEN_BITS-1:0]   cur_pat_reg, cur_pat_next;
    logic [LEN_BITS-1:0]   cur_len_reg, cur_len_next;
    logic [LEN_BITS-1:0]   max_pat_reg, max_pat_next;
    logic [LEN_BITS-1:0]   max_len_reg, max_len_next;
    logic                  seq_open_reg, seq_open_next;

    logic    result_valid_reg, result_valid_next;
    result_t result_reg, result_next;

    logic [WIDE_ID_BITS-1:0] ev_wide, ev2_wide;
    logic [IDX_BITS-1:0]     ev_idx, ev2_idx;
    logic                    ev2_in_range;

    row_t                  cur_row, new_row, tbl_wrow;
    logic                  upd_we, tbl_we;
    logic [IDX_BITS-1:0]   tbl_waddr;
    logic                  opening;
    logic [COUNT_BITS-1:0] seq_eff;
    logic [LEN_BITS-1:0]   pat_base, len_base;
    logic [COUNT_BITS-1:0] q_sup, q_nf;

    assign ev_wide      = WIDE_ID_BITS'(ev.id);
    assign ev_idx       = ev_wide[IDX_BITS-1:0];
    assign ev2_wide     = WIDE_ID_BITS'(ev2_reg.id);
    assign ev2_idx      = ev2_wide[IDX_BITS-1:0];
    assign ev2_in_range = (ev2_wide < WIDE_COUNT);

    // The previous write was read before it landed; take it from here.
    assign cur_row = (fwd_valid_reg && fwd_addr_reg == ev2_idx) ? fwd_row_reg : rd_row_reg;

    assign opening  = !seq_open_reg;
    assign seq_eff  = (opening && seq_num_reg != CMAX) ? seq_num_reg + 1'b1 : seq_num_reg;
    assign pat_base = opening ? '0 : cur_pat_reg;
    assign len_base = opening ? '0 : cur_len_reg;
    assign q_sup    = ev2_in_range ? cur_row.sup : '0;
    assign q_nf     = ev2_in_range ? cur_row.nf : '0;

    always_comb
    begin
        seq_num_next      = seq_num_reg;
        cur_pat_next      = cur_pat_reg;
        cur_len_next      = cur_len_reg;
        max_pat_next      = max_pat_reg;
        max_len_next      = max_len_reg;
        seq_open_next     = seq_open_reg;
        upd_we            = 1'b0;
        new_row           = cur_row;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        if (ev2_reg.valid)
        begin
            unique case (ev2_reg.kind)
                EV_QUERY:
                begin
                    result_valid_next            = 1'b1;
                    result_next.entry_id         = ev2_reg.id;
                    result_next.support_count    = OUT_COUNT_BITS'(q_sup);
                    result_next.nonfinal_count   = OUT_COUNT_BITS'(q_nf);
                    result_next.is_frequent      = (OUT_COUNT_BITS'(q_sup) >= min_support);
                    result_next.sequence_total   = OUT_COUNT_BITS'(seq_num_reg);
                    result_next.longest_pattern  = max_pat_reg;
                    result_next.longest_sequence = max_len_reg;
                end
                EV_ITEM:
                begin
                    seq_open_next = 1'b1;
                    seq_num_next  = seq_eff;
                    cur_pat_next  = pat_base;
                    cur_len_next  = len_base;
                    if (!ev2_reg.drop)
                    begin
                        cur_pat_next = sat_add16(pat_base, 2'd1);
                        cur_len_next = sat_add16(len_base, 2'd2);
                        // Count once per sequence: the tag holds the last sequence counted.
                        if (ev2_in_range && cur_row.tag < seq_eff)
                        begin
                            upd_we      = 1'b1;
                            new_row.tag = seq_eff;
                            if (cur_row.sup != CMAX)
                            begin
                                new_row.sup = cur_row.sup + 1'b1;
                            end
                            if (ev2_reg.nonfinal_ok && cur_row.nf != CMAX)
                            begin
                                new_row.nf = cur_row.nf + 1'b1;
                            end
                        end
                    end
                end
                EV_SET_END:
                begin
                    seq_open_next = 1'b1;
                    seq_num_next  = seq_eff;
                    cur_pat_next  = pat_base;
                    cur_len_next  = sat_add16(len_base, 2'd1);
                end
                EV_SEQ_END:
                begin
                    seq_open_next = 1'b0;
                    seq_num_next  = seq_eff;
                    cur_pat_next  = pat_base;
                    cur_len_next  = len_base;
                    if (max_pat_reg < pat_base)
                    begin
                        max_pat_next = pat_base;
                    end
                    if (max_len_reg < len_base)
                    begin
                        max_len_next = len_base;
                    end
                end
                default:
                begin
                    upd_we = 1'b0;
                end
            endcase
        end
    end

    // Zeroing sweep after reset, one entry per cycle.
    always_comb
    begin
        clear_active_next = clear_active_reg;
        clear_addr_next   = clear_addr_reg;
        if (clear_active_reg)
        begin
            clear_addr_next = clear_addr_reg + 1'b1;
            if (clear_addr_reg == LAST_IDX)
            begin
                clear_active_next = 1'b0;
            end
        end
    end

    assign tbl_we    = clear_active_reg || upd_we;
    assign tbl_waddr = clear_active_reg ? clear_addr_reg : ev2_idx;
    assign tbl_wrow  = clear_active_reg ? '0 : new_row;

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= tbl_wrow;
        end
        rd_row_reg   <= tbl_mem[ev_idx];
        fwd_addr_reg <= ev2_idx;
        fwd_row_reg  <= new_row;
        result_reg   <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
            fwd_valid_reg    <= 1'b0;
            ev2_reg          <= '0;
            seq_num_reg      <= '0;
            cur_pat_reg      <= '0;
            cur_len_reg      <= '0;
            max_pat_reg      <= '0;
            max_len_reg      <= '0;
            seq_open_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            clear_active_reg <= clear_active_next;
            clear_addr_reg   <= clear_addr_next;
            fwd_valid_reg    <= upd_we;
            ev2_reg          <= ev;
            seq_num_reg      <= seq_num_next;
            cur_pat_reg      <= cur_pat_next;
            cur_len_reg      <= cur_len_next;
            max_pat_reg      <= max_pat_next;
            max_len_reg      <= max_len_next;
            seq_open_reg     <= seq_open_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign clearing     = clear_active_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_no_event_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clear_active_reg |-> !ev.valid)
        else $error("event arrived during the table clearing sweep");

    a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> $past(ev2_reg.valid && ev2_reg.kind == EV_QUERY))
        else $error("result strobe without a query in the update stage");

    a_close_on_mark: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(seq_open_reg) |-> $past(ev2_reg.valid && ev2_reg.kind == EV_SEQ_END))
        else $error("sequence closed without an end-of-sequence event");

    a_update_only_items: assert property (@(posedge clk) disable iff (!rst_n)
        upd_we |-> (ev2_reg.kind == EV_ITEM && !ev2_reg.drop && !clear_active_reg))
        else $error("table update from an event that may not count");

endmodule

// ----- design/sequence_item_support_counter_top.sv -----
// Sequence item support counter. Requests are tokens of a sequence database (item ids,
// end-of-itemset and end-of-sequence marks) or queries of one item's entry. A request is
// taken at a rising edge where start is high and busy is low. Each item counts at most once
// per sequence; a second counter skips occurrences whose first or second successor is the
// end of the sequence, and an item token directly followed by the same item is dropped. A
// token is only counted once the token two places after it has arrived (or its sequence has
// ended), so a query sees those tokens only. While busy is low one request is taken per
// cycle, set by the single read-modify-write of the counter memory, which forwards the
// previous write to the next access. An end-of-sequence mark holds busy high while the
// tokens still waiting in the two-token window drain ahead of it. A query answer passes the
// window event register, the update stage register and the result register, and appears on
// result with result_valid high for exactly one cycle; the receiver cannot hold it, so it
// must be captured then. Stream tokens give no answer.
// After reset busy stays high while the counter memory is zeroed, one entry per cycle;
// min_support may be written during that time. min_support is written through cfg_we and
// cfg_wdata and should only change while no request is in flight.
module sequence_item_support_counter_top
    import sisc_pkg::*;
#(
    parameter int ITEM_COUNT = 1024,
    parameter int COUNT_BITS = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  cmd_t                      cmd,
    output logic                      result_valid,
    output result_t                   result,
    input  logic                      cfg_we,
    input  logic [OUT_COUNT_BITS-1:0] cfg_wdata
);

    logic [OUT_COUNT_BITS-1:0] min_support_reg;
    logic                      accept;
    logic                      pending;
    logic                      clearing;
    event_t                    ev;

    // The threshold register takes writes at any time, also during the clearing sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_support_reg <= MIN_SUPPORT_RESET;
        end
        else if (cfg_we)
        begin
            min_support_reg <= cfg_wdata;
        end
    end

    // Busy covers both the memory sweep and the drain of the lookahead window.
    assign busy   = clearing || pending;
    assign accept = start && !busy;

    // Front end: lookahead window that turns tokens into ordered update events.
    sisc_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .cmd     (cmd),
        .pending (pending),
        .ev      (ev)
    );

    // Back end: counter memory read-modify-write, sequence statistics and query answers.
    sisc_update #(
        .ITEM_COUNT (ITEM_COUNT),
        .COUNT_BITS (COUNT_BITS)
    ) u_update (
        .clk          (clk),
        .rst_n        (rst_n),
        .ev           (ev),
        .min_support  (min_support_reg),
        .clearing     (clearing),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
